@@ src/tcs_pkg.sv @@
package tcs_pkg;

    localparam int TERM_COLS = 79;
    localparam int TERM_ROWS = 24;
    localparam int NUM_CELLS = TERM_COLS * TERM_ROWS;
    localparam int ADDR_W    = $clog2(NUM_CELLS);
    localparam int ROW_W     = 5;
    localparam int COL_W     = 7;
    localparam int KIND_W    = 2;
    localparam int CELL_W    = 16;

    localparam logic [7:0] BLANK_CHAR    = 8'h20;
    localparam logic [7:0] ATTR_AT_RESET = 8'h07;
    localparam logic [7:0] CODE_CR       = 8'd13;
    localparam logic [7:0] CODE_LF       = 8'd10;
    localparam logic [7:0] CODE_BS       = 8'd8;
    localparam logic [7:0] CODE_PRINT    = 8'h20;

    localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_BLANK,
        ST_PUT,
        ST_READ,
        ST_CLEAR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [CELL_W-1:0] wdata;
    } ram_req_t;

    // first field in the highest bits
    typedef struct packed {
        logic [COL_W-1:0]  read_col;
        logic [ROW_W-1:0]  read_row;
        logic [7:0]        char_code;
        logic [KIND_W-1:0] kind;
    } item_t;

    typedef struct packed {
        logic [7:0]       cell_attr;
        logic [7:0]       cell_char;
        logic [COL_W-1:0] cursor_col;
        logic [ROW_W-1:0] cursor_row;
    } result_t;

    // logical row to stored row, with top as the stored index of logical row 0
    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] row,
                                                  input logic [ROW_W-1:0] top);
        logic [ROW_W:0] sum;
        sum = {1'b0, row} + {1'b0, top};
        if (sum >= (ROW_W+1)'(TERM_ROWS))
            sum = sum - (ROW_W+1)'(TERM_ROWS);
        return sum[ROW_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(prow) * ADDR_W'(TERM_COLS) + ADDR_W'(col);
    endfunction

endpackage

@@ src/tcs_cell_ram.sv @@
module tcs_cell_ram (
    input  logic                              clk,
    input  tcs_pkg::ram_req_t                 req,
    output logic [tcs_pkg::CELL_W-1:0]        rdata
);
    import tcs_pkg::*;

    logic [CELL_W-1:0] cell_mem [NUM_CELLS];
    logic [CELL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
            cell_mem[req.addr] <= req.wdata;
        if (req.re)
            rdata_reg <= cell_mem[req.addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/tcs_ctrl.sv @@
module tcs_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  tcs_pkg::item_t               in_item,
    output logic                         res_valid,
    input  logic                         res_ready,
    output tcs_pkg::result_t             res,
    input  logic [7:0]                   fill_attr,
    output tcs_pkg::ram_req_t            ram_req,
    input  logic [tcs_pkg::CELL_W-1:0]   ram_rdata
);
    import tcs_pkg::*;

    state_t            state_reg,    state_next;
    logic [ROW_W-1:0]  row_reg,      row_next;
    logic [COL_W-1:0]  col_reg,      col_next;
    logic [ROW_W-1:0]  top_reg,      top_next;
    logic [ADDR_W-1:0] addr_reg,     addr_next;
    logic [COL_W-1:0]  cnt_reg,      cnt_next;
    logic              pend_reg,     pend_next;
    item_t             item_reg,     item_next;
    logic [CELL_W-1:0] cell_reg,     cell_next;

    logic              rd_in_range;
    logic              at_bottom;

    assign rd_in_range = (item_reg.read_row < ROW_W'(TERM_ROWS))
                      && (item_reg.read_col < COL_W'(TERM_COLS));
    assign at_bottom   = (row_reg == ROW_W'(TERM_ROWS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            row_reg   <= '0;
            col_reg   <= '0;
            top_reg   <= '0;
            addr_reg  <= '0;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            item_reg  <= '0;
            cell_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            top_reg   <= top_next;
            addr_reg  <= addr_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            item_reg  <= item_next;
            cell_reg  <= cell_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        top_next   = top_reg;
        addr_next  = addr_reg;
        cnt_next   = cnt_reg;
        pend_next  = pend_reg;
        item_next  = item_reg;
        cell_next  = cell_reg;
        in_ready   = 1'b0;
        res_valid  = 1'b0;
        ram_req    = '0;

        case (state_reg)
            ST_INIT:
            begin
                ram_req.we    = 1'b1;
                ram_req.addr  = addr_reg;
                ram_req.wdata = {ATTR_AT_RESET, BLANK_CHAR};
                addr_next     = addr_reg + 1'b1;
                if (addr_reg == ADDR_W'(NUM_CELLS - 1))
                begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    item_next  = in_item;
                    cell_next  = '0;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                state_next = ST_DONE;
                case (item_reg.kind)
                    KIND_PUT:
                    begin
                        if (item_reg.char_code == CODE_CR)
                            col_next = '0;
                        else if (item_reg.char_code == CODE_LF
                              || (item_reg.char_code >= CODE_PRINT
                                  && col_reg >= COL_W'(TERM_COLS)))
                        begin
                            pend_next = (item_reg.char_code != CODE_LF);
                            col_next  = '0;
                            if (at_bottom)
                            begin
                                // scroll: old top row becomes the new bottom row
                                addr_next  = cell_addr(top_reg, '0);
                                cnt_next   = '0;
                                top_next   = (top_reg == ROW_W'(TERM_ROWS - 1))
                                           ? '0 : top_reg + 1'b1;
                                state_next = ST_BLANK;
                            end
                            else
                            begin
                                row_next   = row_reg + 1'b1;
                                state_next = (item_reg.char_code != CODE_LF)
                                           ? ST_PUT : ST_DONE;
                            end
                        end
                        else if (item_reg.char_code == CODE_BS)
                        begin
                            if (col_reg != '0)
                                col_next = col_reg - 1'b1;
                            else if (row_reg != '0)
                            begin
                                row_next = row_reg - 1'b1;
                                col_next = COL_W'(TERM_COLS - 1);
                            end
                            state_next = ST_PUT;
                        end
                        else if (item_reg.char_code >= CODE_PRINT)
                            state_next = ST_PUT;
                    end

                    KIND_READ:
                    begin
                        if (rd_in_range)
                        begin
                            ram_req.re   = 1'b1;
                            ram_req.addr = cell_addr(phys_row(item_reg.read_row, top_reg),
                                                     item_reg.read_col);
                            state_next   = ST_READ;
                        end
                    end

                    KIND_CLEAR:
                    begin
                        row_next   = '0;
                        col_next   = '0;
                        top_next   = '0;
                        addr_next  = '0;
                        state_next = ST_CLEAR;
                    end

                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end

            ST_BLANK:
            begin
                ram_req.we    = 1'b1;
                ram_req.addr  = addr_reg;
                ram_req.wdata = {fill_attr, BLANK_CHAR};
                addr_next     = addr_reg + 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == COL_W'(TERM_COLS - 1))
                    state_next = pend_reg ? ST_PUT : ST_DONE;
            end

            ST_PUT:
            begin
                ram_req.we   = 1'b1;
                ram_req.addr = cell_addr(phys_row(row_reg, top_reg), col_reg);
                if (item_reg.char_code == CODE_BS)
                    ram_req.wdata = {fill_attr, BLANK_CHAR};
                else
                begin
                    ram_req.wdata = {fill_attr, item_reg.char_code};
                    col_next      = col_reg + 1'b1;
                end
                state_next = ST_DONE;
            end

            ST_READ:
            begin
                cell_next  = ram_rdata;
                state_next = ST_DONE;
            end

            ST_CLEAR:
            begin
                ram_req.we    = 1'b1;
                ram_req.addr  = addr_reg;
                ram_req.wdata = {fill_attr, BLANK_CHAR};
                addr_next     = addr_reg + 1'b1;
                if (addr_reg == ADDR_W'(NUM_CELLS - 1))
                begin
                    addr_next  = '0;
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                    state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res.cursor_row = row_reg;
    assign res.cursor_col = col_reg;
    assign res.cell_char  = cell_reg[7:0];
    assign res.cell_attr  = cell_reg[15:8];

endmodule

@@ src/text_terminal_cursor_scroll_core.sv @@
// Character-cell text terminal buffer, 24 rows by 79 columns.
// s_axis carries one item: put character, read cell or clear screen.
// Every item gives exactly one m_axis item with the cursor after the item
// and, for an in-range read, the cell's character and attribute.
// cfg_valid/cfg_data write the default attribute; cfg_ready is always high.
// Work per item, accept to result valid:
//   CR, ignored codes, unused kind, out-of-range read: no cell access
//   printable or backspace: one cell write; read: one cell read
//   line feed on the last row: 79-cell row blank; printable with a
//   pending wrap on the last row: row blank, then the cell write
//   clear screen: sweep over all 1896 cells
// The row blank and clear sweeps write one cell per cycle through the single
// port of the cell store; scrolling only moves a row pointer.
// After reset the cell store is filled with blanks (attribute 0x07) in a
// pass over every cell; s_axis_tready stays low until it ends.
// The result sits in an output register; the next item is accepted while it
// waits. If m_axis stalls, a second result waits in the sequencer and no
// further item is accepted until the output register frees up.
module text_terminal_cursor_scroll_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // kind[1:0], char_code[9:2], read_row[14:10],
                                        // read_col[21:15]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // cursor_row[4:0], cursor_col[11:5],
                                        // cell_char[19:12], cell_attr[27:20]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);
    import tcs_pkg::*;

    logic [7:0]        attr_reg;
    logic              out_valid_reg;
    result_t           out_reg;
    logic              res_valid;
    logic              res_ready;
    result_t           res;
    item_t             in_item;
    ram_req_t          ram_req;
    logic [CELL_W-1:0] ram_rdata;

    assign in_item   = item_t'(s_axis_tdata[$bits(item_t)-1:0]);
    assign cfg_ready = 1'b1;
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg      <= ATTR_AT_RESET;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (cfg_valid)
                attr_reg <= cfg_data;
            if (res_ready)
            begin
                out_valid_reg <= res_valid;
                if (res_valid)
                    out_reg <= res;
            end
        end
    end

    tcs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_item      (in_item),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .fill_attr    (attr_reg),
        .ram_req      (ram_req),
        .ram_rdata    (ram_rdata)
    );

    tcs_cell_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(32 - $bits(result_t)){1'b0}}, out_reg};

endmodule

@@ sim/text_terminal_cursor_scroll_core_test.sv @@
module text_terminal_cursor_scroll_core_test;
    import tcs_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int END_WAIT_CYCLES = 2000;
    localparam int PHASE_ITEMS = 220;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // kind, char_code, read_row, read_col
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [31:0] m_axis_tdata;        // cursor_row, cursor_col, cell_char, cell_attr
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = '0;

    text_terminal_cursor_scroll_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // screen shadow
    logic [7:0]       screen_char [TERM_ROWS][TERM_COLS];
    logic [7:0]       screen_attr [TERM_ROWS][TERM_COLS];
    logic [ROW_W-1:0] cur_row;
    logic [COL_W-1:0] cur_col;
    logic [7:0]       attr_now;

    result_t cursor_cell_q [$];

    bit gaps_on = 1'b1;
    int stall_left = 0;
    int mismatch_count = 0;
    int items_total = 0;
    int replies_checked = 0;
    int read_hits = 0;
    int scroll_count = 0;
    int wrap_count = 0;
    int clear_count = 0;
    int attr_set_count = 0;

    function void blank_cell(input int r, input int c);
        screen_char[r][c] = BLANK_CHAR;
        screen_attr[r][c] = attr_now;
    endfunction

    function void home_and_blank();
        for (int r = 0; r < TERM_ROWS; r++)
            for (int c = 0; c < TERM_COLS; c++)
                blank_cell(r, c);
        cur_row = '0;
        cur_col = '0;
    endfunction

    function void next_row();
        cur_col = '0;
        if (int'(cur_row) + 1 >= TERM_ROWS)
        begin
            for (int r = 0; r < TERM_ROWS - 1; r++)
                for (int c = 0; c < TERM_COLS; c++)
                begin
                    screen_char[r][c] = screen_char[r+1][c];
                    screen_attr[r][c] = screen_attr[r+1][c];
                end
            for (int c = 0; c < TERM_COLS; c++)
                blank_cell(TERM_ROWS - 1, c);
            scroll_count++;
        end
        else
        begin
            cur_row = cur_row + 1'b1;
        end
    endfunction

    function result_t predict_terminal_step(input item_t it);
        result_t res;
        res = '0;
        case (it.kind)
            KIND_PUT:
            begin
                case (it.char_code)
                    CODE_CR: cur_col = '0;
                    CODE_LF: next_row();
                    CODE_BS:
                    begin
                        if (cur_col > 0)
                            cur_col = cur_col - 1'b1;
                        else if (cur_row > 0)
                        begin
                            cur_row = cur_row - 1'b1;
                            cur_col = COL_W'(TERM_COLS - 1);
                        end
                        blank_cell(cur_row, cur_col);
                    end
                    default:
                    begin
                        if (it.char_code >= CODE_PRINT)
                        begin
                            if (int'(cur_col) >= TERM_COLS)
                            begin
                                next_row();
                                wrap_count++;
                            end
                            screen_char[cur_row][cur_col] = it.char_code;
                            screen_attr[cur_row][cur_col] = attr_now;
                            cur_col = cur_col + 1'b1;
                        end
                    end
                endcase
            end
            KIND_READ:
            begin
                if (it.read_row < TERM_ROWS && it.read_col < TERM_COLS)
                begin
                    res.cell_char = screen_char[it.read_row][it.read_col];
                    res.cell_attr = screen_attr[it.read_row][it.read_col];
                    read_hits++;
                end
            end
            KIND_CLEAR:
            begin
                home_and_blank();
                clear_count++;
            end
            default: ;
        endcase
        res.cursor_row = cur_row;
        res.cursor_col = cur_col;
        return res;
    endfunction

    function item_t make_item(input logic [KIND_W-1:0] kind, input logic [7:0] code,
                              input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
        item_t it;
        it.kind      = kind;
        it.char_code = code;
        it.read_row  = row;
        it.read_col  = col;
        return it;
    endfunction

    function void compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // reply checking and receiver stalls
    always @(posedge clk)
    begin : reply_check
        result_t got;
        result_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[27:0];
            if (cursor_cell_q.size() == 0)
            begin
                $display("%0t: reply with none expected, actual %h", $time, m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                want = cursor_cell_q.pop_front();
                compare_field("cursor_row", want.cursor_row, got.cursor_row);
                compare_field("cursor_col", want.cursor_col, got.cursor_col);
                compare_field("cell_char", want.cell_char, got.cell_char);
                compare_field("cell_attr", want.cell_attr, got.cell_attr);
                replies_checked++;
            end
        end
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end
        else if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left = $urandom_range(1, 7) - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic issue_term_item(input item_t it);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, it};
        do @(posedge clk); while (!s_axis_tready);
        cursor_cell_q.push_back(predict_terminal_step(it));
        items_total++;
    endtask

    task automatic wait_replies_done();
        s_axis_tvalid <= 1'b0;
        while (cursor_cell_q.size() != 0) @(posedge clk);
    endtask

    task automatic set_fill_attr(input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        attr_now = v;
        attr_set_count++;
    endtask

    task automatic put_code(input logic [7:0] code);
        issue_term_item(make_item(KIND_PUT, code, ROW_W'($urandom), COL_W'($urandom)));
    endtask

    task automatic read_cell(input int row, input int col);
        issue_term_item(make_item(KIND_READ, 8'($urandom), ROW_W'(row), COL_W'(col)));
    endtask

    task automatic clear_screen();
        issue_term_item(make_item(KIND_CLEAR, 8'($urandom), ROW_W'($urandom),
                                  COL_W'($urandom)));
    endtask

    task automatic put_printable();
        put_code(8'($urandom_range(32, 255)));
    endtask

    task automatic put_ignored_control();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 31));
        while (c == CODE_CR || c == CODE_LF || c == CODE_BS);
        put_code(c);
    endtask

    task automatic type_text_line();
        int len;
        int p;
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(70, 100) : $urandom_range(0, 12);
        for (int i = 0; i < len; i++)
        begin
            p = $urandom_range(0, 99);
            if (p < 80)
                put_printable();
            else if (p < 88)
                read_cell(cur_row, $urandom_range(0, TERM_COLS - 1));
            else if (p < 94)
                put_code(CODE_BS);
            else if (p < 96)
                put_ignored_control();
            else
                read_cell($urandom_range(0, TERM_ROWS - 1), $urandom_range(0, TERM_COLS - 1));
        end
        p = $urandom_range(0, 9);
        if (p < 6)
        begin
            put_code(CODE_CR);
            put_code(CODE_LF);
        end
        else if (p < 8)
            put_code(CODE_LF);
        else if (p < 9)
            put_code(CODE_CR);
    endtask

    // raw items with every field random; clears kept rare
    task automatic send_noise();
        item_t it;
        repeat ($urandom_range(1, 4))
        begin
            it = item_t'(($bits(item_t))'($urandom));
            if (it.kind == KIND_CLEAR && $urandom_range(0, 7) != 0)
                it.kind = KIND_READ;
            issue_term_item(it);
        end
    endtask

    task automatic run_sequence();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            send_noise();
        else if (r == 1 && $urandom_range(0, 2) == 0)
            clear_screen();
        else
            type_text_line();
    endtask

    task automatic test_reset_contents();
        read_cell(0, 0);
        read_cell(TERM_ROWS - 1, TERM_COLS - 1);
        read_cell(12, 40);
    endtask

    task automatic test_control_codes();
        clear_screen();
        put_code(CODE_BS);
        put_code(CODE_PRINT);
        put_code(8'hFF);
        put_code(8'h41);
        read_cell(0, 0);
        read_cell(0, 1);
        read_cell(0, 2);
        put_code(CODE_BS);
        read_cell(0, 2);
        put_code(CODE_CR);
        put_code(CODE_LF);
        put_code(8'h00);
        put_code(8'h1F);
        put_code(8'h09);
        issue_term_item(make_item(KIND_UNUSED, 8'($urandom), ROW_W'($urandom),
                                  COL_W'($urandom)));
        put_code(CODE_BS);
        read_cell(0, TERM_COLS - 1);
        read_cell(TERM_ROWS, 0);
        read_cell(0, TERM_COLS);
        read_cell(31, 127);
    endtask

    task automatic test_line_wrap_scroll();
        clear_screen();
        repeat (TERM_COLS) put_printable();
        read_cell(0, TERM_COLS - 1);
        put_code(CODE_BS);
        read_cell(0, TERM_COLS - 1);
        put_printable();
        put_printable();
        read_cell(1, 0);
        repeat (TERM_ROWS) put_code(CODE_LF);
        repeat (TERM_COLS + 1) put_printable();
        read_cell(TERM_ROWS - 1, 0);
        read_cell(TERM_ROWS - 2, TERM_COLS - 1);
        read_cell(0, 0);
        put_code(CODE_CR);
        put_code(CODE_BS);
        read_cell(TERM_ROWS - 2, TERM_COLS - 1);
    endtask

    task automatic test_random_session();
        logic [7:0] fixed_attrs [3];
        int stop_at;
        fixed_attrs = '{8'h1E, 8'h80, 8'hF0};
        for (int k = 0; k < 6; k++)
        begin
            set_fill_attr((k % 2 == 0) ? fixed_attrs[k / 2] : 8'($urandom_range(0, 255)));
            stop_at = items_total + PHASE_ITEMS;
            while (items_total < stop_at)
                run_sequence();
            wait_replies_done();
        end
    endtask

    task automatic test_unthrottled_tail();
        int stop_at;
        gaps_on = 1'b0;
        set_fill_attr(ATTR_AT_RESET);
        stop_at = items_total + PHASE_ITEMS;
        while (items_total < stop_at)
            run_sequence();
        wait_replies_done();
    endtask

    initial
    begin
        attr_now = ATTR_AT_RESET;
        home_and_blank();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_contents();
        wait_replies_done();
        set_fill_attr(8'h00);
        test_control_codes();
        wait_replies_done();
        set_fill_attr(8'hFF);
        test_line_wrap_scroll();
        wait_replies_done();
        test_random_session();
        test_unthrottled_tail();
        repeat (END_WAIT_CYCLES) @(posedge clk);
        $display("covered %0d items, %0d replies checked, %0d reads of on-screen cells",
                 items_total, replies_checked, read_hits);
        $display("scrolls %0d, deferred wraps %0d, clears %0d, %0d attribute settings",
                 scroll_count, wrap_count, clear_count, attr_set_count);
        if (mismatch_count == 0 && cursor_cell_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

@@ text_terminal_cursor_scroll_core.f @@
src/tcs_pkg.sv
src/tcs_cell_ram.sv
src/tcs_ctrl.sv
src/text_terminal_cursor_scroll_core.sv
sim/text_terminal_cursor_scroll_core_test.sv
